// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: design/tsff_pkg.sv
// Types and constants of the toroidal seed flood fill block.
package tsff_pkg;

    localparam int CMD_W   = 2;
    localparam int KIND_W  = 2;
    localparam int COORD_W = 6;
    localparam int COUNT_W = 13;
    localparam int COORD_N = 1 << COORD_W;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_cmd CMD_WRITE = 2'd0;
    localparam t_cmd CMD_FILL  = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;

    localparam t_kind KIND_WALL     = 2'd0;
    localparam t_kind KIND_CORRIDOR = 2'd1;
    localparam t_kind KIND_ROOM     = 2'd2;

    // Neighbour step along one axis
    typedef logic [1:0] t_step;
    localparam t_step STEP_DEC  = 2'd0;
    localparam t_step STEP_HOLD = 2'd1;
    localparam t_step STEP_INC  = 2'd2;

    localparam int NBR_N  = 8;
    localparam int NBR_AW = 3;

    localparam t_step STEP_X [NBR_N] = '{STEP_HOLD, STEP_HOLD, STEP_DEC, STEP_INC,
                                         STEP_DEC, STEP_INC, STEP_DEC, STEP_INC};
    localparam t_step STEP_Y [NBR_N] = '{STEP_DEC, STEP_INC, STEP_HOLD, STEP_HOLD,
                                         STEP_DEC, STEP_DEC, STEP_INC, STEP_INC};

endpackage

// File: design/tsff_req_if.sv
// Request channel of the flood fill block: valid, ready and command payload.
interface tsff_req_if;
    import tsff_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   command;
    t_coord x;
    t_coord y;
    t_kind  cell_type;
    logic   room_mode;

    modport source (output valid, command, x, y, cell_type, room_mode, input ready);
    modport sink   (input valid, command, x, y, cell_type, room_mode, output ready);
endinterface

// File: design/tsff_rsp_if.sv
// Response channel of the flood fill block: valid, ready and cell result payload.
interface tsff_rsp_if;
    import tsff_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  cell_kind;
    logic   is_seen;
    t_count open_cells;
    t_count corridor_cells;

    modport source (output valid, cell_kind, is_seen, open_cells, corridor_cells, input ready);
    modport sink   (input valid, cell_kind, is_seen, open_cells, corridor_cells, output ready);
endinterface

// File: design/toroidal_seed_flood_fill_top.sv
// Toroidal seed flood fill: cell kind store, seen map and queue-driven 8-connected fill.
//
//  channel | dir | handshake     | payload
//  i_req   | in  | valid / ready | command, x, y, cell_type, room_mode
//  o_rsp   | out | valid / ready | cell_kind, is_seen, open_cells, corridor_cells
//
// Write/read: a memory read in the accepting cycle, then write-back and result.
// Fill: accept, a sweep of the S = 2^(clog2(W)+clog2(H)) seen-map addresses, final read;
//   room mode adds the seed, a check that finds the queue empty and, per queued cell,
//   a queue read and 8 neighbour read/update pairs, each waiting on its memory read.
// After reset a pass over the S addresses wipes both maps; i_req.ready stays low meanwhile.
// The result register lets a new request in while the last result waits on o_rsp.ready.
module toroidal_seed_flood_fill_top #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsff_req_if.sink  i_req,
    tsff_rsp_if.source o_rsp
);
    import tsff_pkg::*;

    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int MEM_D = 1 << AW;
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int QAW   = $clog2(CELLS);
    localparam int QCW   = $clog2(CELLS + 1);

    localparam logic [XW-1:0]  X_LAST = XW'(GRID_WIDTH - 1);
    localparam logic [YW-1:0]  Y_LAST = YW'(GRID_HEIGHT - 1);
    localparam logic [QCW-1:0] Q_FULL = QCW'(CELLS);

    typedef enum logic [10:0] {
        S_INIT = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_WR   = 11'b000_0000_0100,
        S_RDD  = 11'b000_0000_1000,
        S_RES  = 11'b000_0001_0000,
        S_CLR  = 11'b000_0010_0000,
        S_SEED = 11'b000_0100_0000,
        S_POP  = 11'b000_1000_0000,
        S_NBR  = 11'b001_0000_0000,
        S_CHK  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } t_state;

    // Storage
    t_kind         mem_kind  [MEM_D];
    logic          mem_seen  [MEM_D];
    logic [AW-1:0] mem_queue [CELLS];

    // Control registers
    t_state           r_state, n_state;
    logic [AW-1:0]    r_sweep, n_sweep;
    logic [QCW-1:0]   r_head, n_head;
    logic [QCW-1:0]   r_tail, n_tail;
    logic [NBR_AW-1:0] r_k, n_k;
    t_count           r_open, n_open;
    t_count           r_corr, n_corr;
    logic             r_o_valid, n_o_valid;

    // Payload registers
    logic [AW-1:0] r_addr, n_addr;
    t_kind         r_kind, n_kind;
    logic          r_flood, n_flood;
    logic [AW-1:0] r_n, n_n;
    t_kind         r_res_kind, n_res_kind;
    logic          r_res_seen, n_res_seen;
    t_kind         r_o_kind, n_o_kind;
    logic          r_o_seen, n_o_seen;
    t_count        r_o_open, n_o_open;
    t_count        r_o_corr, n_o_corr;
    t_kind         r_kind_rd;
    logic          r_seen_rd;
    logic [AW-1:0] r_q_rd;

    // Memory ports
    logic           mem_re;
    logic [AW-1:0]  mem_ra;
    logic           kind_we;
    logic [AW-1:0]  kind_wa;
    t_kind          kind_wd;
    logic           seen_we;
    logic [AW-1:0]  seen_wa;
    logic           seen_wd;
    logic           q_we;
    logic [QAW-1:0] q_wa;
    logic [AW-1:0]  q_wd;
    logic           q_re;

    logic           res_load;
    t_kind          res_kind;
    logic           res_seen;
    logic           out_free;

    // Coordinate wrap tables
    logic [XW-1:0] x_wrap [COORD_N];
    logic [YW-1:0] y_wrap [COORD_N];
    logic [AW-1:0] req_addr;

    for (genvar v = 0; v < COORD_N; v++) begin : g_wrap
        assign x_wrap[v] = XW'(v % GRID_WIDTH);
        assign y_wrap[v] = YW'(v % GRID_HEIGHT);
    end

    assign req_addr = {y_wrap[i_req.y], x_wrap[i_req.x]};

    // Neighbour of the current queue cell
    logic [XW-1:0] cx, nx;
    logic [YW-1:0] cy, ny;
    logic [AW-1:0] nbr_addr;

    assign cx = r_q_rd[XW-1:0];
    assign cy = r_q_rd[AW-1:XW];

    always_comb begin
        case (STEP_X[r_k])
            STEP_DEC:  nx = (cx == '0) ? X_LAST : cx - 1'b1;
            STEP_INC:  nx = (cx == X_LAST) ? '0 : cx + 1'b1;
            STEP_HOLD: nx = cx;
            default:   nx = cx;
        endcase
        case (STEP_Y[r_k])
            STEP_DEC:  ny = (cy == '0) ? Y_LAST : cy - 1'b1;
            STEP_INC:  ny = (cy == Y_LAST) ? '0 : cy + 1'b1;
            STEP_HOLD: ny = cy;
            default:   ny = cy;
        endcase
    end

    assign nbr_addr = {ny, nx};

    assign out_free    = !r_o_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_sweep    = r_sweep;
        n_head     = r_head;
        n_tail     = r_tail;
        n_k        = r_k;
        n_open     = r_open;
        n_corr     = r_corr;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_addr     = r_addr;
        n_kind     = r_kind;
        n_flood    = r_flood;
        n_n        = r_n;
        n_res_kind = r_res_kind;
        n_res_seen = r_res_seen;
        n_o_kind   = r_o_kind;
        n_o_seen   = r_o_seen;
        n_o_open   = r_o_open;
        n_o_corr   = r_o_corr;

        mem_re   = 1'b0;
        mem_ra   = req_addr;
        kind_we  = 1'b0;
        kind_wa  = r_addr;
        kind_wd  = r_kind;
        seen_we  = 1'b0;
        seen_wa  = r_sweep;
        seen_wd  = 1'b0;
        q_we     = 1'b0;
        q_wa     = r_tail[QAW-1:0];
        q_wd     = r_addr;
        q_re     = 1'b0;
        res_load = 1'b0;
        res_kind = r_kind_rd;
        res_seen = r_seen_rd;

        case (r_state)
            S_INIT: begin
                // wipe both maps after reset
                kind_we = 1'b1;
                kind_wa = r_sweep;
                kind_wd = KIND_WALL;
                seen_we = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (&r_sweep) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    mem_re  = 1'b1;
                    n_addr  = req_addr;
                    n_kind  = i_req.cell_type;
                    n_flood = i_req.room_mode;
                    n_head  = '0;
                    n_tail  = '0;
                    case (i_req.command)
                        CMD_WRITE: n_state = S_WR;
                        CMD_FILL:  n_state = S_CLR;
                        CMD_READ:  n_state = S_RDD;
                        default:   n_state = S_RDD;
                    endcase
                end
            end
            S_WR: begin
                kind_we = 1'b1;
                if (r_kind_rd == KIND_WALL && r_kind != KIND_WALL) begin
                    n_open = r_open + 1'b1;
                end else if (r_kind_rd != KIND_WALL && r_kind == KIND_WALL) begin
                    n_open = r_open - 1'b1;
                end
                if (r_kind_rd == KIND_CORRIDOR && r_kind != KIND_CORRIDOR) begin
                    n_corr = r_corr - 1'b1;
                end else if (r_kind_rd != KIND_CORRIDOR && r_kind == KIND_CORRIDOR) begin
                    n_corr = r_corr + 1'b1;
                end
                res_kind = r_kind;
                res_load = 1'b1;
            end
            S_RDD: begin
                res_load = 1'b1;
            end
            S_RES: begin
                res_kind = r_res_kind;
                res_seen = r_res_seen;
                res_load = 1'b1;
            end
            S_CLR: begin
                seen_we = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (&r_sweep) begin
                    n_state = r_flood ? S_SEED : S_FIN;
                end
            end
            S_SEED: begin
                // seed is seen and queued whatever its kind
                seen_we = 1'b1;
                seen_wa = r_addr;
                seen_wd = 1'b1;
                q_we    = 1'b1;
                n_tail  = r_tail + 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                if (r_head == r_tail) begin
                    n_state = S_FIN;
                end else begin
                    q_re    = 1'b1;
                    n_head  = r_head + 1'b1;
                    n_k     = '0;
                    n_state = S_NBR;
                end
            end
            S_NBR: begin
                mem_re  = 1'b1;
                mem_ra  = nbr_addr;
                n_n     = nbr_addr;
                n_state = S_CHK;
            end
            S_CHK: begin
                // mark unseen neighbour; queue it only when it is room
                if (!r_seen_rd) begin
                    seen_we = 1'b1;
                    seen_wa = r_n;
                    seen_wd = 1'b1;
                    if (r_kind_rd == KIND_ROOM && r_tail != Q_FULL) begin
                        q_we   = 1'b1;
                        q_wd   = r_n;
                        n_tail = r_tail + 1'b1;
                    end
                end
                n_k     = r_k + 1'b1;
                n_state = (r_k == NBR_AW'(NBR_N - 1)) ? S_POP : S_NBR;
            end
            S_FIN: begin
                mem_re  = 1'b1;
                mem_ra  = r_addr;
                n_state = S_RDD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the result to the output register, or park it while the sink stalls
        if (res_load) begin
            if (out_free) begin
                n_o_valid = 1'b1;
                n_o_kind  = res_kind;
                n_o_seen  = res_seen;
                n_o_open  = n_open;
                n_o_corr  = n_corr;
                n_state   = S_IDLE;
            end else begin
                n_res_kind = res_kind;
                n_res_seen = res_seen;
                n_state    = S_RES;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_sweep   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_k       <= '0;
            r_open    <= '0;
            r_corr    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sweep   <= n_sweep;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_k       <= n_k;
            r_open    <= n_open;
            r_corr    <= n_corr;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_kind     <= n_kind;
        r_flood    <= n_flood;
        r_n        <= n_n;
        r_res_kind <= n_res_kind;
        r_res_seen <= n_res_seen;
        r_o_kind   <= n_o_kind;
        r_o_seen   <= n_o_seen;
        r_o_open   <= n_o_open;
        r_o_corr   <= n_o_corr;
    end

    always_ff @(posedge i_clk) begin
        if (kind_we) begin
            mem_kind[kind_wa] <= kind_wd;
        end
        if (seen_we) begin
            mem_seen[seen_wa] <= seen_wd;
        end
        if (mem_re) begin
            r_kind_rd <= mem_kind[mem_ra];
            r_seen_rd <= mem_seen[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            mem_queue[q_wa] <= q_wd;
        end
        if (q_re) begin
            r_q_rd <= mem_queue[r_head[QAW-1:0]];
        end
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.cell_kind      = r_o_kind;
    assign o_rsp.is_seen        = r_o_seen;
    assign o_rsp.open_cells     = r_o_open;
    assign o_rsp.corridor_cells = r_o_corr;

endmodule

// File: design/tsff_checker.sv
// Port-level checks of the flood fill block and their bind to the top level.
`include "assert_macros.svh"

module tsff_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input tsff_pkg::t_kind  i_rsp_kind,
    input logic             i_rsp_seen,
    input tsff_pkg::t_count i_rsp_open,
    input tsff_pkg::t_count i_rsp_corr
);
    import tsff_pkg::*;

    logic                        rsp_stall;
    logic [KIND_W+2*COUNT_W:0]   rsp_payload;

    assign rsp_stall   = i_rsp_valid && !i_rsp_ready;
    assign rsp_payload = {i_rsp_kind, i_rsp_seen, i_rsp_open, i_rsp_corr};

    // one request at a time: busy right after taking one
    `ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // a fresh result only ever leaves a busy block
    `ASSERT_IMP(a_rsp_from_busy, i_clk, i_rst_n, $rose(i_rsp_valid), !$past(i_req_ready))

    // hold a stalled result and its counts
    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, i_rsp_valid && $stable(rsp_payload))

endmodule

bind toroidal_seed_flood_fill_top tsff_checker u_tsff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_kind  (o_rsp.cell_kind),
    .i_rsp_seen  (o_rsp.is_seen),
    .i_rsp_open  (o_rsp.open_cells),
    .i_rsp_corr  (o_rsp.corridor_cells)
);
